// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/wudiv_pkg.sv -----
// ----------------------------------------------------------------------------
// wudiv_pkg
// Shared constants and types of the 256 by 128 bit divider.
// ----------------------------------------------------------------------------
package wudiv_pkg;

   localparam int WORD_W      = 64;
   localparam int DIVIDEND_W  = 256;
   localparam int DIVISOR_W   = 128;
   localparam int NUM_CELLS   = 8;
   localparam int SLICE_W     = DIVISOR_W / NUM_CELLS;   // remainder/divisor bits per cell
   localparam int NUM_SLICE_W = DIVIDEND_W / NUM_CELLS;  // dividend/quotient bits per cell
   localparam int CNT_W       = $clog2(DIVIDEND_W);

   // control broadcast to every cell
   typedef struct packed {
      logic load;   // take new operands
      logic step;   // perform one restoring step
      logic ge;     // shifted remainder >= divisor this step
   } wudiv_ctl_type;

endpackage

// ----- rtl/wudiv_if.sv -----
// ----------------------------------------------------------------------------
// wudiv channel interfaces
// Valid/ready channels for operand and result transactions.
// ----------------------------------------------------------------------------
interface wudiv_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] dividend_w0;
   logic [63:0] dividend_w1;
   logic [63:0] dividend_w2;
   logic [63:0] dividend_w3;
   logic [63:0] divisor_lo;
   logic [63:0] divisor_hi;

   modport source (
      output valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
             divisor_lo, divisor_hi,
      input  ready
   );
   modport sink (
      input  valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
             divisor_lo, divisor_hi,
      output ready
   );
endinterface

interface wudiv_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] quotient_w0;
   logic [63:0] quotient_w1;
   logic [63:0] quotient_w2;
   logic [63:0] quotient_w3;
   logic [63:0] remainder_lo;
   logic [63:0] remainder_hi;
   logic        divide_by_zero;

   modport source (
      output valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_lo, remainder_hi, divide_by_zero,
      input  ready
   );
   modport sink (
      input  valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
             remainder_lo, remainder_hi, divide_by_zero,
      output ready
   );
endinterface

// ----- rtl/wudiv_cell.sv -----
// ----------------------------------------------------------------------------
// wudiv_cell
// One slice of the divider: remainder, divisor and dividend/quotient bits.
// ----------------------------------------------------------------------------
module wudiv_cell (
   input  logic                                   clock,
   input  wudiv_pkg::wudiv_ctl_type               ctl,
   input  logic [wudiv_pkg::NUM_SLICE_W-1:0]      ld_num,
   input  logic [wudiv_pkg::SLICE_W-1:0]          ld_div,
   input  logic                                   rem_bit_in,
   input  logic                                   num_bit_in,
   input  logic                                   borrow_in,
   output logic                                   rem_msb,
   output logic                                   num_msb,
   output logic                                   borrow_out,
   output logic [wudiv_pkg::SLICE_W-1:0]          rem_slice,
   output logic [wudiv_pkg::NUM_SLICE_W-1:0]      num_slice
);
   import wudiv_pkg::*;

   logic [SLICE_W-1:0]     rem_ff, rem_in;
   logic [SLICE_W-1:0]     div_ff, div_in;
   logic [NUM_SLICE_W-1:0] num_ff, num_in;
   logic [SLICE_W-1:0]     shifted;
   logic [SLICE_W:0]       diff;

   // borrow ripples up from the neighbour below
   assign shifted = {rem_ff[SLICE_W-2:0], rem_bit_in};
   assign diff    = {1'b0, shifted} - {1'b0, div_ff} - {{SLICE_W{1'b0}}, borrow_in};

   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      num_in = num_ff;
      if (ctl.load) begin
         rem_in = '0;
         div_in = ld_div;
         num_in = ld_num;
      end else if (ctl.step) begin
         rem_in = ctl.ge ? diff[SLICE_W-1:0] : shifted;
         num_in = {num_ff[NUM_SLICE_W-2:0], num_bit_in};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      num_ff <= num_in;
   end

   assign rem_msb    = rem_ff[SLICE_W-1];
   assign num_msb    = num_ff[NUM_SLICE_W-1];
   assign borrow_out = diff[SLICE_W];
   assign rem_slice  = rem_ff;
   assign num_slice  = num_ff;

endmodule

// ----- rtl/wide_unsigned_divider_256_by_128.sv -----
// ----------------------------------------------------------------------------
// wide_unsigned_divider_256_by_128
// 256-bit by 128-bit unsigned restoring divider built from a row of slice cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    dividend_w0..w3, divisor_lo, divisor_hi
//   rsp      out  valid / ready    quotient_w0..w3, remainder_lo/hi, divide_by_zero
//
// Operation: the cells load the operands, then run 256 steps of the shared 129-bit
//   compare/subtract (one quotient bit each), then the result is registered. A new
//   transaction is accepted only when idle, once the last result has left the cells.
// Reset: clears the sequencer and the result valid only; no clearing pass.
// Stalls: the result sits in the output register, so the next transaction can
//   load and run; a finished result waits in the cells until that register frees.
//
`include "assert_macros.svh"

module wide_unsigned_divider_256_by_128 (
   input  logic         clock,
   input  logic         reset,
   wudiv_req_if.sink    req_chan,
   wudiv_rsp_if.source  rsp_chan
);
   import wudiv_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             dz_ff, dz_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic                  rdz_ff, rdz_in;

   wudiv_ctl_type ctl;
   logic          req_acc;
   logic          out_free;
   logic          xfer;

   // cell row wiring
   logic [NUM_CELLS-1:0]                  rem_msb, num_msb, borrow;
   logic [NUM_CELLS-1:0][SLICE_W-1:0]     rem_all;
   logic [NUM_CELLS-1:0][NUM_SLICE_W-1:0] num_all;
   logic [NUM_CELLS-1:0][NUM_SLICE_W-1:0] ld_num;
   logic [NUM_CELLS-1:0][SLICE_W-1:0]     ld_div;

   assign ld_num = {req_chan.dividend_w3, req_chan.dividend_w2,
                    req_chan.dividend_w1, req_chan.dividend_w0};
   assign ld_div = {req_chan.divisor_hi, req_chan.divisor_lo};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign xfer           = (state_ff == ST_DONE) && out_free;

   // ge: bit shifted out of the 128-bit remainder, or no borrow out of the top cell
   assign ctl.load = req_acc;
   assign ctl.step = (state_ff == ST_RUN);
   assign ctl.ge   = rem_msb[NUM_CELLS-1] || !borrow[NUM_CELLS-1];

   // ring: dividend msb feeds remainder lsb, quotient bit enters dividend lsb
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic rem_bit, num_bit, bin;
      if (i == 0) begin : g_first
         assign rem_bit = num_msb[NUM_CELLS-1];
         assign num_bit = ctl.ge;
         assign bin     = 1'b0;
      end else begin : g_rest
         assign rem_bit = rem_msb[i-1];
         assign num_bit = num_msb[i-1];
         assign bin     = borrow[i-1];
      end

      wudiv_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ld_num     (ld_num[i]),
         .ld_div     (ld_div[i]),
         .rem_bit_in (rem_bit),
         .num_bit_in (num_bit),
         .borrow_in  (bin),
         .rem_msb    (rem_msb[i]),
         .num_msb    (num_msb[i]),
         .borrow_out (borrow[i]),
         .rem_slice  (rem_all[i]),
         .num_slice  (num_all[i])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dz_in    = dz_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               dz_in    = (req_chan.divisor_lo == '0) && (req_chan.divisor_hi == '0);
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register; zero divisor forces zero quotient and remainder
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rdz_in       = rdz_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
         quo_in       = dz_ff ? '0 : num_all;
         rem_in       = dz_ff ? '0 : rem_all;
         rdz_in       = dz_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dz_ff  <= dz_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      rdz_ff <= rdz_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.quotient_w0    = quo_ff[WORD_W-1:0];
   assign rsp_chan.quotient_w1    = quo_ff[2*WORD_W-1:WORD_W];
   assign rsp_chan.quotient_w2    = quo_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_chan.quotient_w3    = quo_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_chan.remainder_lo   = rem_ff[WORD_W-1:0];
   assign rsp_chan.remainder_hi   = rem_ff[2*WORD_W-1:WORD_W];
   assign rsp_chan.divide_by_zero = rdz_ff;

   // checks
   `ASSERT_NEXT(a_accept_starts_run, clock, reset, req_acc, state_ff == ST_RUN && cnt_ff == '0)
   `ASSERT_IMPLIES(a_done_count_wrapped, clock, reset, state_ff == ST_DONE, cnt_ff == '0)
   `ASSERT_NEXT(a_xfer_sets_valid, clock, reset, xfer, rsp_valid_ff)
   `ASSERT_IMPLIES(a_dz_zero_result, clock, reset, rsp_valid_ff && rdz_ff, quo_ff == '0 && rem_ff == '0)

endmodule
